// ===== rtl/core/mf3_pkg.sv =====
// Shared types, constants and helper functions of the 3x3 median filter.
// Used by every module of the filter; depends on nothing else.

package mf3_pkg;

   localparam int unsigned PixW     = 8;
   localparam int unsigned CfgW     = 12;
   localparam int unsigned CsrDataW = 32;
   localparam int unsigned CsrAddrW = 3;
   localparam int unsigned SizeMax  = (1 << CfgW) - 1;
   localparam int unsigned ColsDefault = 640;
   localparam int unsigned RowsDefault = 480;

   // Bit positions of the four results one input can cause, in delivery order.
   localparam int unsigned ResCenter  = 0;
   localparam int unsigned ResRight   = 1;
   localparam int unsigned ResBottom  = 2;
   localparam int unsigned ResCorner  = 3;
   localparam int unsigned NumRes     = 4;

   typedef logic [PixW-1:0] pixel_type;
   typedef logic [CfgW-1:0] size_type;

   // One window column: index 0 is the oldest row, index 2 the current row.
   typedef logic [2:0][PixW-1:0] column_type;
   // Whole window, element row*3 + col.
   typedef logic [8:0][PixW-1:0] window_type;

   typedef struct packed {
      pixel_type older;
      pixel_type newer;
   } line_pair_type;

   typedef enum logic {
      RegImageCols = 1'b0,
      RegImageRows = 1'b1
   } reg_index_type;

   // Where the pixel of a transaction lies in the frame.
   typedef struct packed {
      logic row_ge1;
      logic row_ge2;
      logic col_ge1;
      logic col_ge2;
      logic col_last;
      logic row_last;
   } pos_type;

   function automatic size_type clamp_size(size_type raw, size_type max_val);
      size_type res;
      if (raw == '0) begin
         res = size_type'(1);
      end else if (raw > max_val) begin
         res = max_val;
      end else begin
         res = raw;
      end
      return res;
   endfunction

endpackage

// ===== rtl/core/mf3_line_store.sv =====
// Line store of the median filter: one memory holding the two previous rows
// as a pixel pair per column, with a registered read. Uses mf3_pkg.

module mf3_line_store #(
   parameter int unsigned DEPTH = 2048
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rd_en,
   input  logic [$clog2(DEPTH)-1:0]    rd_addr,
   input  logic                        wr_en,
   input  logic [$clog2(DEPTH)-1:0]    wr_addr,
   input  mf3_pkg::line_pair_type      wr_data,
   output mf3_pkg::line_pair_type      rd_data
);

   mf3_pkg::line_pair_type mem [DEPTH];
   mf3_pkg::line_pair_type rd_ff;
   mf3_pkg::line_pair_type byp_ff;
   mf3_pkg::line_pair_type byp_in;
   logic                   hit_ff;
   logic                   hit_in;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   // A read of the column written at the same edge takes the new pair.
   always_comb begin
      hit_in = hit_ff;
      byp_in = byp_ff;
      if (rd_en) begin
         hit_in = wr_en && (wr_addr == rd_addr);
         byp_in = wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
      byp_ff <= byp_in;
   end

   assign rd_data = hit_ff ? byp_ff : rd_ff;

endmodule

// ===== rtl/core/mf3_col_cell.sv =====
// One column cell of the 3x3 window: holds three pixels and passes them to
// its older neighbor whenever the window shifts. Uses mf3_pkg.

module mf3_col_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                shift,
   input  mf3_pkg::column_type col_in,
   output mf3_pkg::column_type col_out
);

   mf3_pkg::column_type col_ff;
   mf3_pkg::column_type col_in_sel;

   assign col_in_sel = shift ? col_in : col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else begin
         col_ff <= col_in_sel;
      end
   end

   assign col_out = col_ff;

endmodule

// ===== rtl/core/mf3_median_sel.sv =====
// Rank selector: picks the median (element n/2 in ascending order) of the
// window pixels enabled by a mask. Uses mf3_pkg.

module mf3_median_sel (
   input  mf3_pkg::window_type values,
   input  logic [8:0]          mask,
   output mf3_pkg::pixel_type  median
);

   logic [3:0]         count;
   logic [3:0]         target;
   logic [8:0][3:0]    rank;
   logic [8:0]         pick;
   mf3_pkg::pixel_type acc;

   // Each enabled element counts the enabled elements that sort before it;
   // equal values are ordered by position, so every rank is unique.
   always_comb begin
      count = '0;
      for (int i = 0; i < 9; i++) begin
         count = count + 4'(mask[i]);
      end
      target = count >> 1;
      for (int i = 0; i < 9; i++) begin
         rank[i] = '0;
         for (int j = 0; j < 9; j++) begin
            if (mask[j] && ((values[j] < values[i]) ||
                            ((values[j] == values[i]) && (j < i)))) begin
               rank[i] = rank[i] + 4'd1;
            end
         end
         pick[i] = mask[i] && (rank[i] == target);
      end
      acc = '0;
      for (int i = 0; i < 9; i++) begin
         acc = acc | (values[i] & {mf3_pkg::PixW{pick[i]}});
      end
   end

   assign median = acc;

endmodule

// ===== rtl/core/median_filter_3x3_top.sv =====
// 3x3 median filter, top level. Uses mf3_pkg, mf3_line_store, mf3_col_cell
// and mf3_median_sel.
//
// Pixels enter in raster order on the req_ channel, one per transaction, and
// medians leave on the rsp_ channel. A transaction moves when valid is high
// and stall is low. Each output pixel is the median of the neighbors that lie
// inside the image; results lag the input by one row and one column, and the
// last pixel of a row or of the frame flushes up to four results, marked by
// rsp_last_of_run on the final one and rsp_end_of_frame at the frame's end.
// Frame size is set through the csr_ port (image_cols at 0x0, image_rows at
// 0x4); any write restarts the frame position. Write only while idle.
// A pixel waits in the line-store read stage, is shifted into the chain of
// three column cells, and its first result is then taken into the output
// register. One pixel is taken each cycle while each pixel causes at most one
// result and the receiver does not stall; a pixel that causes more results
// holds the input until the single shared rank selector has made them all.
// Reset clears the window, the position and the registers to 640 x 480; the
// line stores need no clearing. When the receiver stalls, results hold in
// the output register and stall propagates back to req_stall.

module median_filter_3x3_top #(
   parameter int unsigned MAX_COLS = 2048,
   parameter int unsigned MAX_ROWS = 2048
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [mf3_pkg::PixW-1:0]          req_pixel_in,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [mf3_pkg::PixW-1:0]          rsp_median_out,
   output logic                              rsp_last_of_run,
   output logic                              rsp_end_of_frame,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [mf3_pkg::CsrAddrW-1:0]      csr_paddr,
   input  logic [mf3_pkg::CsrDataW-1:0]      csr_pwdata,
   output logic [mf3_pkg::CsrDataW-1:0]      csr_prdata,
   output logic                              csr_pready
);

   localparam int unsigned AW = $clog2(MAX_COLS);
   localparam mf3_pkg::size_type MaxColsCfg =
      mf3_pkg::size_type'((MAX_COLS > mf3_pkg::SizeMax) ? mf3_pkg::SizeMax : MAX_COLS);
   localparam mf3_pkg::size_type MaxRowsCfg =
      mf3_pkg::size_type'((MAX_ROWS > mf3_pkg::SizeMax) ? mf3_pkg::SizeMax : MAX_ROWS);
   localparam mf3_pkg::size_type ColsReset =
      (mf3_pkg::ColsDefault > MaxColsCfg) ? MaxColsCfg : mf3_pkg::size_type'(mf3_pkg::ColsDefault);
   localparam mf3_pkg::size_type RowsReset =
      (mf3_pkg::RowsDefault > MaxRowsCfg) ? MaxRowsCfg : mf3_pkg::size_type'(mf3_pkg::RowsDefault);

   // ---------------- configuration registers ----------------
   mf3_pkg::size_type      cols_ff, cols_in;
   mf3_pkg::size_type      rows_ff, rows_in;
   mf3_pkg::reg_index_type csr_index;
   logic                   csr_write;

   assign csr_pready = 1'b1;
   assign csr_index  = mf3_pkg::reg_index_type'(csr_paddr[2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cols_in = cols_ff;
      rows_in = rows_ff;
      if (csr_write) begin
         case (csr_index)
            mf3_pkg::RegImageCols:
               cols_in = mf3_pkg::clamp_size(csr_pwdata[mf3_pkg::CfgW-1:0], MaxColsCfg);
            mf3_pkg::RegImageRows:
               rows_in = mf3_pkg::clamp_size(csr_pwdata[mf3_pkg::CfgW-1:0], MaxRowsCfg);
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         mf3_pkg::RegImageCols:
            csr_prdata = {{(mf3_pkg::CsrDataW - mf3_pkg::CfgW){1'b0}}, cols_ff};
         mf3_pkg::RegImageRows:
            csr_prdata = {{(mf3_pkg::CsrDataW - mf3_pkg::CfgW){1'b0}}, rows_ff};
         default:
            csr_prdata = '0;
      endcase
   end

   // ---------------- frame position ----------------
   logic              accept;
   mf3_pkg::size_type col_ff, col_in;
   mf3_pkg::size_type row_ff, row_in;
   mf3_pkg::pos_type  pos_now;

   assign accept = req_valid && !req_stall;

   assign pos_now.row_ge1  = (row_ff != '0);
   assign pos_now.row_ge2  = (row_ff > mf3_pkg::size_type'(1));
   assign pos_now.col_ge1  = (col_ff != '0);
   assign pos_now.col_ge2  = (col_ff > mf3_pkg::size_type'(1));
   assign pos_now.col_last = (col_ff == cols_ff - mf3_pkg::size_type'(1));
   assign pos_now.row_last = (row_ff == rows_ff - mf3_pkg::size_type'(1));

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_write) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (pos_now.col_last) begin
            col_in = '0;
            row_in = pos_now.row_last ? '0 : row_ff + mf3_pkg::size_type'(1);
         end else begin
            col_in = col_ff + mf3_pkg::size_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= ColsReset;
         rows_ff <= RowsReset;
         col_ff  <= '0;
         row_ff  <= '0;
      end else begin
         cols_ff <= cols_in;
         rows_ff <= rows_in;
         col_ff  <= col_in;
         row_ff  <= row_in;
      end
   end

   // ---------------- line-store read stage ----------------
   logic                   s1_valid_ff, s1_valid_in;
   mf3_pkg::pixel_type     s1_pixel_ff, s1_pixel_in;
   logic [AW-1:0]          s1_addr_ff, s1_addr_in;
   mf3_pkg::pos_type       s1_pos_ff, s1_pos_in;
   logic                   s1_adv;
   logic                   s2_free;
   mf3_pkg::line_pair_type line_rd;
   mf3_pkg::line_pair_type line_wr;
   mf3_pkg::column_type    new_col;

   assign s1_adv    = s1_valid_ff && s2_free;
   assign req_stall = s1_valid_ff && !s2_free;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_pixel_in = s1_pixel_ff;
      s1_addr_in  = s1_addr_ff;
      s1_pos_in   = s1_pos_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_pixel_in = req_pixel_in;
         s1_addr_in  = AW'(col_ff);
         s1_pos_in   = pos_now;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_pixel_ff <= s1_pixel_in;
      s1_addr_ff  <= s1_addr_in;
      s1_pos_ff   <= s1_pos_in;
   end

   // The column's rows move up by one: newer becomes older, the pixel newer.
   assign line_wr.older = line_rd.newer;
   assign line_wr.newer = s1_pixel_ff;

   mf3_line_store #(
      .DEPTH (MAX_COLS)
   ) u_line_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (AW'(col_ff)),
      .wr_en   (s1_adv),
      .wr_addr (s1_addr_ff),
      .wr_data (line_wr),
      .rd_data (line_rd)
   );

   assign new_col[0] = line_rd.older;
   assign new_col[1] = line_rd.newer;
   assign new_col[2] = s1_pixel_ff;

   // ---------------- window: chain of column cells ----------------
   mf3_pkg::column_type cell_col [3];
   mf3_pkg::window_type window;

   mf3_col_cell u_cell_new (
      .clock   (clock),
      .reset   (reset),
      .shift   (s1_adv),
      .col_in  (new_col),
      .col_out (cell_col[2])
   );

   mf3_col_cell u_cell_mid (
      .clock   (clock),
      .reset   (reset),
      .shift   (s1_adv),
      .col_in  (cell_col[2]),
      .col_out (cell_col[1])
   );

   mf3_col_cell u_cell_old (
      .clock   (clock),
      .reset   (reset),
      .shift   (s1_adv),
      .col_in  (cell_col[1]),
      .col_out (cell_col[0])
   );

   always_comb begin
      for (int rr = 0; rr < 3; rr++) begin
         for (int cc = 0; cc < 3; cc++) begin
            window[rr*3 + cc] = cell_col[cc][rr];
         end
      end
   end

   // ---------------- result sequencer ----------------
   logic [mf3_pkg::NumRes-1:0] pend_ff, pend_in;
   logic [mf3_pkg::NumRes-1:0] pend_new;
   logic [mf3_pkg::NumRes-1:0] sel_oh;
   logic [mf3_pkg::NumRes-1:0] pend_rest;
   mf3_pkg::pos_type           s2_pos_ff, s2_pos_in;
   logic                       out_free;
   logic                       emit;
   logic                       upper_center;
   logic                       left_center;
   logic [2:0]                 row_sel;
   logic [2:0]                 col_sel;
   logic [8:0]                 mask;
   mf3_pkg::pixel_type         median;

   assign pend_new[mf3_pkg::ResCenter] = s1_pos_ff.row_ge1  && s1_pos_ff.col_ge1;
   assign pend_new[mf3_pkg::ResRight]  = s1_pos_ff.row_ge1  && s1_pos_ff.col_last;
   assign pend_new[mf3_pkg::ResBottom] = s1_pos_ff.row_last && s1_pos_ff.col_ge1;
   assign pend_new[mf3_pkg::ResCorner] = s1_pos_ff.row_last && s1_pos_ff.col_last;

   assign sel_oh    = pend_ff & (~pend_ff + mf3_pkg::NumRes'(1));
   assign pend_rest = pend_ff & ~sel_oh;
   assign emit      = (pend_ff != '0) && out_free;
   assign s2_free   = (pend_ff == '0) || (emit && (pend_rest == '0));

   always_comb begin
      pend_in   = pend_ff;
      s2_pos_in = s2_pos_ff;
      if (s1_adv) begin
         pend_in   = pend_new;
         s2_pos_in = s1_pos_ff;
      end else if (emit) begin
         pend_in = pend_rest;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
      s2_pos_ff <= s2_pos_in;
   end

   // Results centered on the middle row reach up to the oldest row; results
   // centered on the middle column reach left to the oldest column.
   assign upper_center = sel_oh[mf3_pkg::ResCenter] || sel_oh[mf3_pkg::ResRight];
   assign left_center  = sel_oh[mf3_pkg::ResCenter] || sel_oh[mf3_pkg::ResBottom];

   assign row_sel[0] = upper_center && s2_pos_ff.row_ge2;
   assign row_sel[1] = upper_center || s2_pos_ff.row_ge1;
   assign row_sel[2] = 1'b1;
   assign col_sel[0] = left_center && s2_pos_ff.col_ge2;
   assign col_sel[1] = left_center || s2_pos_ff.col_ge1;
   assign col_sel[2] = 1'b1;

   always_comb begin
      for (int rr = 0; rr < 3; rr++) begin
         for (int cc = 0; cc < 3; cc++) begin
            mask[rr*3 + cc] = row_sel[rr] && col_sel[cc];
         end
      end
   end

   mf3_median_sel u_median_sel (
      .values (window),
      .mask   (mask),
      .median (median)
   );

   // ---------------- output register ----------------
   logic               rsp_valid_ff, rsp_valid_in;
   mf3_pkg::pixel_type rsp_median_ff, rsp_median_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_eof_ff, rsp_eof_in;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_median_in = rsp_median_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_eof_in    = rsp_eof_ff;
      if (out_free) begin
         rsp_valid_in = emit;
         if (emit) begin
            rsp_median_in = median;
            rsp_last_in   = (pend_rest == '0);
            rsp_eof_in    = (pend_rest == '0) && s2_pos_ff.row_last && s2_pos_ff.col_last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_median_ff <= rsp_median_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_eof_ff    <= rsp_eof_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_median_out   = rsp_median_ff;
   assign rsp_last_of_run  = rsp_last_ff;
   assign rsp_end_of_frame = rsp_eof_ff;

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for median_filter_3x3_top: pixel streams of many frame sizes,
// with every median predicted in the bench and compared field by field.
// Depends on mf3_pkg and the filter RTL only.

module testbench;

   localparam int MaxCols = 2048;
   localparam int MaxRows = 2048;
   localparam int DrainGuard = 200000;

   typedef struct {
      mf3_pkg::pixel_type median;
      logic               last;
      logic               eof;
   } median_rec_type;

   typedef enum {StepPixel, StepCols, StepRows} step_kind_type;

   typedef struct {
      step_kind_type      kind;
      logic [31:0]        value;
      bit                 typed;
      mf3_pkg::pixel_type median;
   } plan_step_type;

   typedef enum {
      TrafficSteady,
      TrafficFeedGaps,
      TrafficDrainStalls,
      TrafficBoth
   } traffic_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic [mf3_pkg::PixW-1:0]     req_pixel_in = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [mf3_pkg::PixW-1:0]     rsp_median_out;
   logic                         rsp_last_of_run;
   logic                         rsp_end_of_frame;
   logic                         csr_psel = 1'b0;
   logic                         csr_penable = 1'b0;
   logic                         csr_pwrite = 1'b0;
   logic [mf3_pkg::CsrAddrW-1:0] csr_paddr = '0;
   logic [mf3_pkg::CsrDataW-1:0] csr_pwdata = '0;
   logic [mf3_pkg::CsrDataW-1:0] csr_prdata;
   logic                         csr_pready;

   // Bench copy of the filter state.
   mf3_pkg::pixel_type line_old [MaxCols];
   mf3_pkg::pixel_type line_new [MaxCols];
   mf3_pkg::pixel_type win [9];
   int          col_pos = 0;
   int          row_pos = 0;
   int          cols_eff = mf3_pkg::ColsDefault;
   int          rows_eff = mf3_pkg::RowsDefault;

   median_rec_type pending_medians [$];
   int          errors = 0;
   int          pixels_sent = 0;
   int          medians_seen = 0;
   int          size_writes = 0;
   int          feed_gap_pct = 0;
   int          drain_stall_pct = 0;
   logic        hold_armed = 1'b0;
   logic        hold_done = 1'b0;
   int          hold_left = 0;

   median_filter_3x3_top #(
      .MAX_COLS(MaxCols),
      .MAX_ROWS(MaxRows)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_pixel_in(req_pixel_in),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_median_out(rsp_median_out),
      .rsp_last_of_run(rsp_last_of_run),
      .rsp_end_of_frame(rsp_end_of_frame),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #6 clock = ~clock;

   initial begin
      #1200000;
      $display("Run exceeded its time budget");
      $display("FAIL");
      $finish;
   end

   // Median of the window block around (wr, wc); only neighbors inside the image count.
   function automatic mf3_pkg::pixel_type window_rank(input int wr, input int wc,
                                                       input bit up, input bit down,
                                                       input bit lf, input bit rt);
      mf3_pkg::pixel_type vals [9];
      mf3_pkg::pixel_type v;
      int n, dr, dc, rr, cc, i, j;
      n = 0;
      for (dr = -1; dr <= 1; dr++) begin
         rr = wr + dr;
         if ((dr < 0 && !up) || (dr > 0 && !down) || rr < 0 || rr > 2) continue;
         for (dc = -1; dc <= 1; dc++) begin
            cc = wc + dc;
            if ((dc < 0 && !lf) || (dc > 0 && !rt) || cc < 0 || cc > 2) continue;
            vals[n] = win[rr * 3 + cc];
            n++;
         end
      end
      for (i = 1; i < n; i++) begin
         v = vals[i];
         j = i - 1;
         while (j >= 0 && vals[j] > v) begin
            vals[j + 1] = vals[j];
            j--;
         end
         vals[j + 1] = v;
      end
      return vals[n / 2];
   endfunction

   function automatic int fit_size(input logic [31:0] raw, input int limit);
      int v;
      v = int'(raw[mf3_pkg::CfgW-1:0]);
      if (v == 0) return 1;
      if (v > limit) return limit;
      return v;
   endfunction

   // Advances the bench state by one pixel and returns the medians it releases.
   task automatic advance_filter(input mf3_pkg::pixel_type px, output int count,
                                 output median_rec_type res [4]);
      mf3_pkg::pixel_type meds [4];
      int c, r, k;
      bit frame_end;
      c = col_pos;
      r = row_pos;
      count = 0;
      if (c >= cols_eff || c >= MaxCols) c = 0;
      if (r >= rows_eff) r = 0;
      for (k = 0; k < 3; k++) begin
         win[k * 3] = win[k * 3 + 1];
         win[k * 3 + 1] = win[k * 3 + 2];
      end
      win[2] = line_old[c];
      win[5] = line_new[c];
      win[8] = px;
      line_old[c] = line_new[c];
      line_new[c] = px;
      if (r >= 1) begin
         if (c >= 1) begin
            meds[count] = window_rank(1, 1, r >= 2, 1'b1, c >= 2, 1'b1);
            count++;
         end
         if (c == cols_eff - 1) begin
            meds[count] = window_rank(1, 2, r >= 2, 1'b1, c >= 1, 1'b0);
            count++;
         end
      end
      if (r == rows_eff - 1) begin
         if (c >= 1) begin
            meds[count] = window_rank(2, 1, r >= 1, 1'b0, c >= 2, 1'b1);
            count++;
         end
         if (c == cols_eff - 1) begin
            meds[count] = window_rank(2, 2, r >= 1, 1'b0, c >= 1, 1'b0);
            count++;
         end
      end
      frame_end = (r == rows_eff - 1) && (c == cols_eff - 1);
      for (k = 0; k < count; k++) begin
         res[k].median = meds[k];
         res[k].last = (k == count - 1);
         res[k].eof = frame_end && (k == count - 1);
      end
      c++;
      if (c >= cols_eff) begin
         c = 0;
         r++;
         if (r >= rows_eff) r = 0;
      end
      col_pos = c;
      row_pos = r;
   endtask

   task automatic set_traffic(input traffic_type mode);
      case (mode)
         TrafficSteady: begin
            feed_gap_pct = 0;
            drain_stall_pct = 0;
         end
         TrafficFeedGaps: begin
            feed_gap_pct = 60;
            drain_stall_pct = 0;
         end
         TrafficDrainStalls: begin
            feed_gap_pct = 0;
            drain_stall_pct = 60;
         end
         default: begin
            feed_gap_pct = 12;
            drain_stall_pct = 12;
         end
      endcase
   endtask

   // Offers one pixel; a typed median replaces the prediction for single-pixel frames.
   task automatic send_pixel(input mf3_pkg::pixel_type px, input bit typed,
                             input mf3_pkg::pixel_type typed_median);
      median_rec_type res [4];
      median_rec_type fixed;
      int count, k;
      while ($urandom_range(99) < feed_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel_in <= px;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      advance_filter(px, count, res);
      if (typed) begin
         fixed.median = typed_median;
         fixed.last = 1'b1;
         fixed.eof = 1'b1;
         pending_medians.insert(pending_medians.size(), fixed);
      end else begin
         for (k = 0; k < count; k++) begin
            pending_medians.insert(pending_medians.size(), res[k]);
         end
      end
      pixels_sent++;
   endtask

   task automatic wait_for_medians(input int settle);
      int guard;
      guard = 0;
      while (pending_medians.size() != 0 && guard < DrainGuard) begin
         @(posedge clock);
         guard++;
      end
      if (pending_medians.size() != 0) begin
         $display("%0t: %0d expected medians never arrived", $time, pending_medians.size());
         errors++;
         pending_medians.delete();
      end
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_size(input mf3_pkg::reg_index_type idx, input logic [31:0] value);
      req_valid <= 1'b0;
      // A pixel in row 0 releases no median but may still be in the pipeline.
      wait_for_medians(8);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (idx == mf3_pkg::RegImageCols) cols_eff = fit_size(value, MaxCols);
      else rows_eff = fit_size(value, MaxRows);
      col_pos = 0;
      row_pos = 0;
      size_writes++;
   endtask

   task automatic read_size(input mf3_pkg::reg_index_type idx, input logic [31:0] expected);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== expected) begin
         $display("%0t: register %s read: expected %0d, got %0d", $time, idx.name(),
                  expected, csr_prdata);
         errors++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_frame(input int cols, input int rows, input bit noisy_upper);
      logic [31:0] upper;
      upper = noisy_upper ? $urandom() : 32'h0;
      write_size(mf3_pkg::RegImageCols,
                 {upper[31:mf3_pkg::CfgW], cols[mf3_pkg::CfgW-1:0]});
      upper = noisy_upper ? $urandom() : 32'h0;
      write_size(mf3_pkg::RegImageRows,
                 {upper[31:mf3_pkg::CfgW], rows[mf3_pkg::CfgW-1:0]});
   endtask

   // Receiver: random stalls, plus one long hold-off that backs the filter up to its input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_armed && !hold_done) begin
         rsp_stall <= 1'b1;
         hold_left <= 300;
         hold_done <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < drain_stall_pct);
      end
   end

   always @(posedge clock) begin
      median_rec_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         medians_seen++;
         if (pending_medians.size() == 0) begin
            $display("%0t: unexpected median: expected none, got %0d", $time, rsp_median_out);
            errors++;
         end else begin
            want = pending_medians.pop_front();
            if (rsp_median_out !== want.median) begin
               $display("%0t: median_out: expected %0d, got %0d", $time, want.median,
                        rsp_median_out);
               errors++;
            end
            if (rsp_last_of_run !== want.last) begin
               $display("%0t: last_of_run: expected %0b, got %0b", $time, want.last,
                        rsp_last_of_run);
               errors++;
            end
            if (rsp_end_of_frame !== want.eof) begin
               $display("%0t: end_of_frame: expected %0b, got %0b", $time, want.eof,
                        rsp_end_of_frame);
               errors++;
            end
         end
      end
   end

   plan_step_type directed_plan [38] = '{
      '{StepPixel, 32'h12, 1'b0, 8'h00},
      '{StepPixel, 32'hED, 1'b0, 8'h00},
      '{StepCols, 32'h0, 1'b0, 8'h00},
      '{StepRows, 32'h0, 1'b0, 8'h00},
      '{StepPixel, 32'h00, 1'b1, 8'h00},
      '{StepPixel, 32'hFF, 1'b1, 8'hFF},
      '{StepPixel, 32'hA5, 1'b1, 8'hA5},
      '{StepPixel, 32'h5A, 1'b1, 8'h5A},
      '{StepCols, 32'd3, 1'b0, 8'h00},
      '{StepRows, 32'd3, 1'b0, 8'h00},
      '{StepPixel, 32'd10, 1'b0, 8'h00},
      '{StepPixel, 32'd200, 1'b0, 8'h00},
      '{StepPixel, 32'd30, 1'b0, 8'h00},
      '{StepPixel, 32'd250, 1'b0, 8'h00},
      '{StepPixel, 32'd0, 1'b0, 8'h00},
      '{StepPixel, 32'd90, 1'b0, 8'h00},
      '{StepPixel, 32'd60, 1'b0, 8'h00},
      '{StepPixel, 32'd70, 1'b0, 8'h00},
      '{StepPixel, 32'd255, 1'b0, 8'h00},
      '{StepCols, 32'd2, 1'b0, 8'h00},
      '{StepRows, 32'd2, 1'b0, 8'h00},
      '{StepPixel, 32'd9, 1'b0, 8'h00},
      '{StepPixel, 32'd200, 1'b0, 8'h00},
      '{StepPixel, 32'd100, 1'b0, 8'h00},
      '{StepPixel, 32'd50, 1'b0, 8'h00},
      '{StepCols, 32'd1, 1'b0, 8'h00},
      '{StepRows, 32'd3, 1'b0, 8'h00},
      '{StepPixel, 32'd40, 1'b0, 8'h00},
      '{StepPixel, 32'd220, 1'b0, 8'h00},
      '{StepPixel, 32'd130, 1'b0, 8'h00},
      '{StepCols, 32'd3, 1'b0, 8'h00},
      '{StepRows, 32'd1, 1'b0, 8'h00},
      '{StepPixel, 32'd77, 1'b0, 8'h00},
      '{StepPixel, 32'd3, 1'b0, 8'h00},
      '{StepPixel, 32'd180, 1'b0, 8'h00},
      '{StepCols, 32'd4095, 1'b0, 8'h00},
      '{StepRows, 32'hFFFF_F002, 1'b0, 8'h00},
      '{StepPixel, 32'd1, 1'b0, 8'h00}
   };

   initial begin
      int phase, item, cols, rows, frames;
      traffic_type mode;
      for (int i = 0; i < MaxCols; i++) begin
         line_old[i] = '0;
         line_new[i] = '0;
      end
      for (int i = 0; i < 9; i++) win[i] = '0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      read_size(mf3_pkg::RegImageCols, 32'(mf3_pkg::ColsDefault));
      read_size(mf3_pkg::RegImageRows, 32'(mf3_pkg::RowsDefault));

      set_traffic(TrafficSteady);
      foreach (directed_plan[i]) begin
         case (directed_plan[i].kind)
            StepCols: write_size(mf3_pkg::RegImageCols, directed_plan[i].value);
            StepRows: write_size(mf3_pkg::RegImageRows, directed_plan[i].value);
            default: send_pixel(directed_plan[i].value[mf3_pkg::PixW-1:0],
                                directed_plan[i].typed, directed_plan[i].median);
         endcase
      end

      // Small random frames under each traffic pattern.
      for (phase = 0; phase < 6; phase++) begin
         mode = traffic_type'(phase % 4);
         set_traffic(mode);
         cols = ($urandom_range(3) == 0) ? 1 : $urandom_range(2, 9);
         rows = ($urandom_range(3) == 0) ? 1 : $urandom_range(2, 6);
         set_frame(cols, rows, 1'b1);
         for (item = 0; item < 12; item++) begin
            if (item == 10) begin
               req_valid <= 1'b0;
               wait_for_medians(1);
            end
            send_pixel(mf3_pkg::pixel_type'($urandom()), 1'b0, '0);
         end
      end

      // Whole frames back to back; a long receiver hold-off fills the filter first.
      set_traffic(TrafficDrainStalls);
      set_frame(4, 3, 1'b1);
      hold_armed <= 1'b1;
      frames = 2;
      repeat (frames * 12) send_pixel(mf3_pkg::pixel_type'($urandom()), 1'b0, '0);

      req_valid <= 1'b0;
      wait_for_medians(20);
      $display("Sent %0d pixels and checked %0d medians across %0d size register writes,",
               pixels_sent, medians_seen, size_writes);
      $display("including clamped sizes, single-row and single-column frames, and stall bursts.");
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
